// ===== src/rom_bank_mapper_with_scanline_irq_defines.svh =====
// assertion macros for the rom bank mapper
// no dependencies; included by the top level
`ifndef ROM_BANK_MAPPER_WITH_SCANLINE_IRQ_DEFINES_SVH
`define ROM_BANK_MAPPER_WITH_SCANLINE_IRQ_DEFINES_SVH

`ifndef ASSERT_OFF
`define RBM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rbm assertion failed");
`define RBM_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("rbm forbidden condition seen");
`else
`define RBM_ASSERT(label, clk, rst, prop)
`define RBM_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== src/rbm_pkg.sv =====
// shared types and constants for the rom bank mapper
// no dependencies
package rbm_pkg;

  localparam int CHR_SLOTS = 8;
  localparam int CHR_IDX_W = $clog2(CHR_SLOTS);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CPU   = 2'd2,
    CMD_PPU   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_ADDRESS_MASK   = 1'b0,
    REG_PRG_BANK_COUNT = 1'b1
  } reg_index_t;

  localparam logic [15:0] ADDR_MASK_RESET  = 16'hFFFF;
  localparam logic [8:0]  BANK_COUNT_RESET = 9'd256;

  localparam logic [3:0]  PAGE_PRG_LOW = 4'h8;
  localparam logic [3:0]  PAGE_PRG_MID = 4'hA;
  localparam logic [3:0]  PAGE_CHR_FIRST = 4'hB;
  localparam logic [3:0]  PAGE_CHR_LAST  = 4'hE;
  localparam logic [15:0] ADDR_MIRROR  = 16'h9000;
  localparam logic [15:0] ADDR_SWAP    = 16'h9008;
  localparam logic [15:0] ADDR_IRQ_LO  = 16'hF000;
  localparam logic [15:0] ADDR_IRQ_HI  = 16'hF004;
  localparam logic [15:0] ADDR_IRQ_CTL = 16'hF008;
  localparam logic [15:0] ADDR_IRQ_ACK = 16'hF00C;

  localparam logic [7:0] MIRROR_IGNORE = 8'hFF;
  localparam logic [7:0] COUNT_TOP     = 8'hFF;

  // view of the bank state used by address translation
  typedef struct packed {
    logic [CHR_SLOTS-1:0][7:0] chr;
    logic [8:0]                bank_count;
    logic [7:0]                prg_low;
    logic [7:0]                prg_mid;
    logic [7:0]                prg_high;
    logic                      high_loaded;
  } rbm_view_t;

endpackage

// ===== src/rom_bank_mapper_with_scanline_irq.sv =====
// Bank mapper with scanline interrupt counter. Takes one transaction per clock
// (register write, scanline tick, cpu or ppu address translate) unless in_stall
// is high, and returns one result per transaction: interrupt pulse, bank number
// and the current mirroring. Throughput is one transaction per cycle while the
// output is not stalled; a transaction is first held in the input register, and
// the decode/update logic then feeds its result into the result register.
// The result register holds under out_stall while the input
// register stays free to take the next transaction until both are full.
// depends on rbm_pkg, rbm_state, rbm_xlate and the defines header
`include "rom_bank_mapper_with_scanline_irq_defines.svh"

module rom_bank_mapper_with_scanline_irq
  import rbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] address,
  input  logic [7:0]  write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        irq_pulse,
  output logic [7:0]  bank_number,
  output logic [1:0]  mirror_mode
);

  logic        s1_valid;
  cmd_t        s1_cmd;
  logic [15:0] s1_address;
  logic [7:0]  s1_value;
  logic        s1_adv;

  logic        step_pulse;
  logic [1:0]  step_mirror;
  logic [7:0]  step_bank;
  rbm_view_t   view;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd     <= cmd_t'(cmd);
      s1_address <= address;
      s1_value   <= write_value;
    end
  end

  rbm_state u_state (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .step           (s1_adv),
    .cmd            (s1_cmd),
    .address        (s1_address),
    .write_value    (s1_value),
    .pulse          (step_pulse),
    .mirroring_next (step_mirror),
    .view           (view)
  );

  rbm_xlate u_xlate (
    .cmd     (s1_cmd),
    .address (s1_address),
    .view    (view),
    .bank    (step_bank)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      irq_pulse   <= step_pulse;
      bank_number <= step_bank;
      mirror_mode <= step_mirror;
    end
  end

  // an interrupt can only come from a scanline tick
  `RBM_ASSERT(a_pulse_on_tick, clk, rst, (s1_adv && step_pulse) |-> (s1_cmd == CMD_TICK))
  // non-translate transactions report bank zero
  `RBM_ASSERT(a_bank_zero, clk, rst, (s1_adv && s1_cmd != CMD_CPU && s1_cmd != CMD_PPU) |=> (bank_number == 8'd0))
  // a held input transaction is not dropped
  `RBM_ASSERT(a_s1_hold, clk, rst, (s1_valid && !s1_adv) |=> s1_valid)
  // the input register never moves into a full, stalled result register
  `RBM_ASSERT_NEVER(a_no_overwrite, clk, rst, s1_adv && out_valid && out_stall)

endmodule

// ===== src/rbm_state.sv =====
// mapper state: config registers, register write decode, irq counter
// depends on rbm_pkg
module rbm_state
  import rbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        step,
  input  cmd_t        cmd,
  input  logic [15:0] address,
  input  logic [7:0]  write_value,
  output logic        pulse,
  output logic [1:0]  mirroring_next,
  output rbm_view_t   view
);

  logic [15:0] address_mask;
  logic [8:0]  prg_bank_count;

  logic [7:0] prg_slot_low,    prg_slot_low_next;
  logic [7:0] prg_slot_mid,    prg_slot_mid_next;
  logic [7:0] prg_slot_high,   prg_slot_high_next;
  logic       prg_high_loaded, prg_high_loaded_next;
  logic       prg_swap,        prg_swap_next;
  logic [CHR_SLOTS-1:0][7:0] chr_banks, chr_banks_next;
  logic [1:0] mirroring;
  logic [1:0] irq_mode,   irq_mode_next;
  logic [7:0] irq_reload, irq_reload_next;
  logic [7:0] irq_count,  irq_count_next;

  logic [15:0] masked;
  logic [3:0]  page;
  logic [11:0] offs;
  logic        prg_reg_hit;
  logic        chr_hit;
  logic [3:0]  chr_page;
  logic [1:0]  chr_sub;
  logic [CHR_IDX_W-1:0] chr_idx;
  logic [1:0]  mode_ack;

  assign masked   = address & address_mask;
  assign page     = masked[15:12];
  assign offs     = masked[11:0];
  assign mode_ack = irq_mode[0] ? 2'b11 : 2'b00;

  // prg registers decode at offsets 0, 4, 8 and C
  assign prg_reg_hit = (offs[11:4] == 8'h00) && (offs[1:0] == 2'b00);

  // chr nibble registers: offsets 0..3 or 0/4/8/C
  assign chr_hit  = (page >= PAGE_CHR_FIRST) && (page <= PAGE_CHR_LAST) &&
                    (offs[11:4] == 8'h00) &&
                    ((offs[3:2] == 2'b00) || (offs[1:0] == 2'b00));
  assign chr_page = page - PAGE_CHR_FIRST;
  assign chr_sub  = (offs[3:2] == 2'b00) ? offs[1:0] : offs[3:2];
  assign chr_idx  = {chr_page[1:0], chr_sub[1]};

  always_comb begin
    prg_slot_low_next    = prg_slot_low;
    prg_slot_mid_next    = prg_slot_mid;
    prg_slot_high_next   = prg_slot_high;
    prg_high_loaded_next = prg_high_loaded;
    prg_swap_next        = prg_swap;
    chr_banks_next       = chr_banks;
    mirroring_next       = mirroring;
    irq_mode_next        = irq_mode;
    irq_reload_next      = irq_reload;
    irq_count_next       = irq_count;
    pulse                = 1'b0;
    if (step) begin
      case (cmd)
        CMD_WRITE: begin
          if (page == PAGE_PRG_LOW && prg_reg_hit) begin
            if (prg_swap) begin
              prg_slot_high_next   = write_value;
              prg_high_loaded_next = 1'b1;
            end else begin
              prg_slot_low_next = write_value;
            end
          end else if (masked == ADDR_MIRROR) begin
            if (write_value != MIRROR_IGNORE) begin
              mirroring_next = write_value[1:0];
            end
          end else if (masked == ADDR_SWAP) begin
            prg_swap_next = write_value[1];
          end else if (page == PAGE_PRG_MID && prg_reg_hit) begin
            prg_slot_mid_next = write_value;
          end else if (chr_hit) begin
            if (chr_sub[0]) begin
              chr_banks_next[chr_idx][7:4] = write_value[3:0];
            end else begin
              chr_banks_next[chr_idx][3:0] = write_value[3:0];
            end
          end else if (masked == ADDR_IRQ_LO) begin
            irq_reload_next[3:0] = write_value[3:0];
          end else if (masked == ADDR_IRQ_HI) begin
            irq_reload_next[7:4] = write_value[3:0];
          end else if (masked == ADDR_IRQ_CTL) begin
            irq_mode_next = write_value[1:0];
            if (write_value[1]) begin
              irq_count_next = irq_reload;
            end
          end else if (masked == ADDR_IRQ_ACK) begin
            irq_mode_next = mode_ack;
          end
        end
        CMD_TICK: begin
          if (irq_mode[1]) begin
            if (irq_count == COUNT_TOP) begin
              pulse          = 1'b1;
              irq_count_next = irq_reload;
              irq_mode_next  = mode_ack;
            end else begin
              irq_count_next = irq_count + 8'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_mask   <= ADDR_MASK_RESET;
      prg_bank_count <= BANK_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ADDRESS_MASK:   address_mask   <= cfg_data;
        REG_PRG_BANK_COUNT: prg_bank_count <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_slot_low    <= 8'd0;
      prg_slot_mid    <= 8'd1;
      prg_high_loaded <= 1'b0;
      prg_swap        <= 1'b0;
      for (int i = 0; i < CHR_SLOTS; i++) begin
        chr_banks[i] <= 8'(i);
      end
      mirroring  <= 2'd0;
      irq_mode   <= 2'd0;
      irq_reload <= 8'd0;
      irq_count  <= 8'd0;
    end else begin
      prg_slot_low    <= prg_slot_low_next;
      prg_slot_mid    <= prg_slot_mid_next;
      prg_high_loaded <= prg_high_loaded_next;
      prg_swap        <= prg_swap_next;
      chr_banks       <= chr_banks_next;
      mirroring       <= mirroring_next;
      irq_mode        <= irq_mode_next;
      irq_reload      <= irq_reload_next;
      irq_count       <= irq_count_next;
    end
  end

  // only read once the loaded flag is set
  always_ff @(posedge clk) begin
    prg_slot_high <= prg_slot_high_next;
  end

  assign view.chr         = chr_banks;
  assign view.bank_count  = prg_bank_count;
  assign view.prg_low     = prg_slot_low;
  assign view.prg_mid     = prg_slot_mid;
  assign view.prg_high    = prg_slot_high;
  assign view.high_loaded = prg_high_loaded;

endmodule

// ===== src/rbm_xlate.sv =====
// cpu and ppu address translation to bank numbers
// depends on rbm_pkg
module rbm_xlate
  import rbm_pkg::*;
(
  input  cmd_t        cmd,
  input  logic [15:0] address,
  input  rbm_view_t   view,
  output logic [7:0]  bank
);

  logic [7:0] last_bank;
  logic [7:0] second_last;

  // fixed banks wrap modulo 256
  assign last_bank   = view.bank_count[7:0] - 8'd1;
  assign second_last = view.bank_count[7:0] - 8'd2;

  always_comb begin
    bank = 8'd0;
    case (cmd)
      CMD_CPU: begin
        if (address[15]) begin
          case (address[14:13])
            2'd0:    bank = view.prg_low;
            2'd1:    bank = view.prg_mid;
            2'd2:    bank = view.high_loaded ? view.prg_high : second_last;
            default: bank = last_bank;
          endcase
        end
      end
      CMD_PPU: begin
        bank = view.chr[address[10 +: CHR_IDX_W]];
      end
      default: begin
        bank = 8'd0;
      end
    endcase
  end

endmodule

// ===== test/tb_rom_bank_mapper_with_scanline_irq.sv =====
`timescale 1ns / 100ps
// testbench for rom_bank_mapper_with_scanline_irq: a directed table, then random
// writes, ticks and translates checked against an in-bench model of the mapper
// depends on rbm_pkg and the rom_bank_mapper_with_scanline_irq top level
module tb_rom_bank_mapper_with_scanline_irq;
  import rbm_pkg::*;

  typedef struct packed {
    logic       pulse;
    logic [7:0] bank;
    logic [1:0] mirror;
  } map_result_t;

  typedef struct {
    cmd_t        op;
    logic [15:0] addr;
    logic [7:0]  data;
    bit          typed;
    map_result_t res;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [15:0] address;
  logic [7:0]  write_value;
  logic        out_valid;
  logic        out_stall;
  logic        irq_pulse;
  logic [7:0]  bank_number;
  logic [1:0]  mirror_mode;

  // model copy of the mapper state and its registers
  logic [15:0] addr_mask;
  logic [8:0]  bank_count;
  logic [7:0]  bank_low;
  logic [7:0]  bank_mid;
  logic [7:0]  bank_high;
  logic        bank_high_valid;
  logic        swap_on;
  logic [7:0]  chr_bank [CHR_SLOTS];
  logic [1:0]  mirror_now;
  logic [1:0]  irq_mode;
  logic [7:0]  irq_reload;
  logic [7:0]  irq_count;

  map_result_t pending_results [$];
  int          mismatch_count = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  // untyped rows are checked against the model
  table_row_t directed_rows [0:26] = '{
    '{CMD_CPU,   16'h0000, 8'h00, 1'b1, {1'b0, 8'h00, 2'd0}},
    '{CMD_CPU,   16'h8000, 8'h00, 1'b1, {1'b0, 8'h00, 2'd0}},
    '{CMD_CPU,   16'hA000, 8'h00, 1'b1, {1'b0, 8'h01, 2'd0}},
    '{CMD_CPU,   16'hC000, 8'h00, 1'b1, {1'b0, 8'hFE, 2'd0}},
    '{CMD_CPU,   16'hFFFF, 8'h00, 1'b1, {1'b0, 8'hFF, 2'd0}},
    '{CMD_PPU,   16'h0000, 8'h00, 1'b1, {1'b0, 8'h00, 2'd0}},
    '{CMD_PPU,   16'h1FFF, 8'h00, 1'b1, {1'b0, 8'h07, 2'd0}},
    '{CMD_PPU,   16'hFC00, 8'h00, 1'b1, {1'b0, 8'h07, 2'd0}},
    '{CMD_TICK,  16'h0000, 8'h00, 1'b1, {1'b0, 8'h00, 2'd0}},
    '{CMD_WRITE, 16'h9000, 8'h03, 1'b1, {1'b0, 8'h00, 2'd3}},
    '{CMD_WRITE, 16'h9000, 8'hFF, 1'b1, {1'b0, 8'h00, 2'd3}},
    '{CMD_WRITE, 16'h8000, 8'hFF, 1'b0, '0},
    '{CMD_CPU,   16'h9FFF, 8'h00, 1'b0, '0},
    '{CMD_WRITE, 16'h9008, 8'h02, 1'b0, '0},
    '{CMD_WRITE, 16'h800C, 8'h5A, 1'b0, '0},
    '{CMD_CPU,   16'hDFFF, 8'h00, 1'b0, '0},
    '{CMD_WRITE, 16'hA00C, 8'h80, 1'b0, '0},
    '{CMD_WRITE, 16'hB001, 8'h0A, 1'b0, '0},
    '{CMD_WRITE, 16'hE00C, 8'h0F, 1'b0, '0},
    '{CMD_PPU,   16'h1C00, 8'h00, 1'b0, '0},
    '{CMD_WRITE, 16'hF000, 8'h0E, 1'b0, '0},
    '{CMD_WRITE, 16'hF004, 8'h0F, 1'b0, '0},
    '{CMD_WRITE, 16'hF008, 8'h03, 1'b0, '0},
    '{CMD_TICK,  16'h0000, 8'h00, 1'b0, '0},
    '{CMD_TICK,  16'h0000, 8'h00, 1'b1, {1'b1, 8'h00, 2'd3}},
    '{CMD_WRITE, 16'h1234, 8'h55, 1'b1, {1'b0, 8'h00, 2'd3}},
    '{CMD_CPU,   16'h7FFF, 8'h00, 1'b1, {1'b0, 8'h00, 2'd3}}
  };

  rom_bank_mapper_with_scanline_irq u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .address     (address),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .irq_pulse   (irq_pulse),
    .bank_number (bank_number),
    .mirror_mode (mirror_mode)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one transaction to the model state and returns its result
  function automatic map_result_t mapper_step(input cmd_t op, input logic [15:0] addr,
                                              input logic [7:0] data);
    map_result_t r;
    logic [15:0] a;
    logic [3:0]  page;
    logic [11:0] offs;
    logic [3:0]  pair;
    logic [1:0]  sub;
    logic [2:0]  slot;
    logic [8:0]  fixed;
    bit          hit;
    r = '0;
    case (op)
      CMD_WRITE: begin
        a = addr & addr_mask;
        page = a[15:12];
        offs = a[11:0];
        if (page == PAGE_PRG_LOW && (offs & ~12'h00C) == 12'h000) begin
          if (swap_on) begin
            bank_high = data;
            bank_high_valid = 1'b1;
          end else begin
            bank_low = data;
          end
        end else if (a == ADDR_MIRROR) begin
          if (data != MIRROR_IGNORE) mirror_now = data[1:0];
        end else if (a == ADDR_SWAP) begin
          swap_on = data[1];
        end else if (page == PAGE_PRG_MID && (offs & ~12'h00C) == 12'h000) begin
          bank_mid = data;
        end else if (page >= PAGE_CHR_FIRST && page <= PAGE_CHR_LAST) begin
          // two chr slots per page, nibble select from bits 1..0 or 3..2
          hit = 1'b1;
          sub = 2'd0;
          if (offs <= 12'd3) sub = offs[1:0];
          else if (offs == 12'h4 || offs == 12'h8 || offs == 12'hC) sub = offs[3:2];
          else hit = 1'b0;
          if (hit) begin
            pair = page - PAGE_CHR_FIRST;
            slot = {pair[1:0], sub[1]};
            if (sub[0]) chr_bank[slot][7:4] = data[3:0];
            else chr_bank[slot][3:0] = data[3:0];
          end
        end else if (a == ADDR_IRQ_LO) begin
          irq_reload[3:0] = data[3:0];
        end else if (a == ADDR_IRQ_HI) begin
          irq_reload[7:4] = data[3:0];
        end else if (a == ADDR_IRQ_CTL) begin
          irq_mode = data[1:0];
          if (irq_mode[1]) irq_count = irq_reload;
        end else if (a == ADDR_IRQ_ACK) begin
          irq_mode = {2{irq_mode[0]}};
        end
      end
      CMD_TICK: begin
        if (irq_mode[1]) begin
          if (irq_count == COUNT_TOP) begin
            r.pulse = 1'b1;
            irq_count = irq_reload;
            irq_mode = {2{irq_mode[0]}};
          end else begin
            irq_count = irq_count + 8'd1;
          end
        end
      end
      CMD_CPU: begin
        if (addr[15]) begin
          case (addr[14:13])
            2'd0: r.bank = bank_low;
            2'd1: r.bank = bank_mid;
            2'd2: begin
              fixed = bank_count - 9'd2;
              r.bank = bank_high_valid ? bank_high : fixed[7:0];
            end
            default: begin
              fixed = bank_count - 9'd1;
              r.bank = fixed[7:0];
            end
          endcase
        end
      end
      CMD_PPU: begin
        r.bank = chr_bank[addr[12:10]];
      end
      default: begin
      end
    endcase
    r.mirror = mirror_now;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic idle_gap(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_transaction(input cmd_t op, input logic [15:0] addr,
                                  input logic [7:0] data, input bit typed,
                                  input map_result_t want);
    map_result_t predicted;
    if (!quiet && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 5));
    @(negedge clk);
    in_valid <= 1'b1;
    cmd <= op;
    address <= addr;
    write_value <= data;
    do @(posedge clk); while (in_stall);
    predicted = mapper_step(op, addr, data);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain_pipeline();
    idle_gap(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ADDRESS_MASK) addr_mask = value;
    else bank_count = value[8:0];
  endtask

  // ticks, translates, mostly decodable writes; exercises irq counter and banks
  task automatic random_items(input int count);
    int          kind;
    cmd_t        op;
    logic [15:0] addr;
    logic [15:0] hit_addr;
    logic [7:0]  data;
    logic [11:0] offs;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      data = 8'($urandom_range(0, 255));
      addr = 16'($urandom_range(0, 16'hFFFF));
      if (kind < 35) begin
        op = CMD_WRITE;
        case ($urandom_range(0, 7))
          0: addr = 16'h8000 | 16'($urandom_range(0, 3) << 2);
          1: addr = ADDR_MIRROR;
          2: addr = ADDR_SWAP;
          3: addr = 16'hA000 | 16'($urandom_range(0, 3) << 2);
          4, 5: begin
            case ($urandom_range(0, 6))
              0, 1, 2, 3: offs = 12'($urandom_range(0, 3));
              4: offs = 12'h4;
              5: offs = 12'h8;
              default: offs = 12'hC;
            endcase
            addr = {4'($urandom_range(PAGE_CHR_FIRST, PAGE_CHR_LAST)), offs};
          end
          6: addr = 16'hF000 | 16'($urandom_range(0, 3) << 2);
          default: ;
        endcase
        // bits the mask drops are don't care on variant boards
        addr = addr | (16'($urandom) & ~addr_mask);
        hit_addr = addr & addr_mask;
        if (hit_addr == ADDR_MIRROR && $urandom_range(0, 3) == 0) data = MIRROR_IGNORE;
        if (hit_addr == ADDR_IRQ_HI && $urandom_range(0, 1) == 1) data[3:0] = 4'hF;
      end else if (kind < 65) begin
        op = CMD_TICK;
      end else if (kind < 85) begin
        op = CMD_CPU;
      end else begin
        op = CMD_PPU;
        if ($urandom_range(0, 3) != 0) addr = 16'($urandom_range(0, 16'h1FFF));
      end
      send_transaction(op, addr, data, 1'b0, '0);
    end
  endtask

  // result side: random stall bursts, one long hold-off on request
  initial begin
    int stall_left;
    int run_left;
    int hold_left;
    bit stall_next;
    out_stall = 1'b0;
    stall_left = 0;
    run_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 40;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (quiet) begin
        stall_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        stall_next = 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(0, 4);
        stall_next = 1'b1;
      end else begin
        run_left = $urandom_range(0, 15);
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    map_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction pending, bank", int'(bank_number), 0);
      end else begin
        want = pending_results.pop_front();
        if (irq_pulse !== want.pulse)
          report_mismatch("irq_pulse", int'(irq_pulse), int'(want.pulse));
        if (bank_number !== want.bank)
          report_mismatch("bank_number", int'(bank_number), int'(want.bank));
        if (mirror_mode !== want.mirror)
          report_mismatch("mirror_mode", int'(mirror_mode), int'(want.mirror));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("rom_bank_mapper_with_scanline_irq regression: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_ADDRESS_MASK;
    cfg_data = 16'h0000;
    in_valid = 1'b0;
    cmd = CMD_WRITE;
    address = 16'h0000;
    write_value = 8'h00;
    addr_mask = ADDR_MASK_RESET;
    bank_count = BANK_COUNT_RESET;
    bank_low = 8'd0;
    bank_mid = 8'd1;
    bank_high = 8'd0;
    bank_high_valid = 1'b0;
    swap_on = 1'b0;
    foreach (chr_bank[i]) chr_bank[i] = 8'(i);
    mirror_now = 2'd0;
    irq_mode = 2'd0;
    irq_reload = 8'd0;
    irq_count = 8'd0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_transaction(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                       directed_rows[i].typed, directed_rows[i].res);
    random_items(300);

    drain_pipeline();
    write_register(REG_ADDRESS_MASK, 16'hF00C);
    write_register(REG_PRG_BANK_COUNT, 16'd2);
    random_items(100);
    hold_req = 1'b1;
    random_items(250);

    drain_pipeline();
    write_register(REG_ADDRESS_MASK, 16'h0000);
    write_register(REG_PRG_BANK_COUNT, 16'd255);
    random_items(150);

    drain_pipeline();
    write_register(REG_ADDRESS_MASK, 16'($urandom_range(0, 16'hFFFF)));
    write_register(REG_PRG_BANK_COUNT, 16'($urandom_range(2, 256)));
    random_items(300);

    // last stretch runs at full rate on both sides
    drain_pipeline();
    write_register(REG_ADDRESS_MASK, 16'hFFFF);
    write_register(REG_PRG_BANK_COUNT, 16'd256);
    quiet = 1'b1;
    random_items(400);

    idle_gap(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rom_bank_mapper_with_scanline_irq regression: pass");
    end else begin
      $display("rom_bank_mapper_with_scanline_irq regression: fail");
    end
    $finish;
  end

endmodule

// ===== rom_bank_mapper_with_scanline_irq.f =====
+incdir+src
src/rbm_pkg.sv
src/rbm_state.sv
src/rbm_xlate.sv
src/rom_bank_mapper_with_scanline_irq.sv
test/tb_rom_bank_mapper_with_scanline_irq.sv
